// ===== design/pft_pkg.sv =====
// ----------------------------------------------------------------------------
// pft_pkg
// Shared widths, operation codes, the controller command word and the
// lowest-set-bit encoder for the page frame table.
// ----------------------------------------------------------------------------
package pft_pkg;

  // table geometry
  localparam int MAX_FRAMES = 64;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int PID_W      = 8;
  localparam int PAGE_W     = 16;
  localparam int ENTRY_W    = PID_W + PAGE_W;
  localparam int OP_W       = 2;

  // frame count register reset value
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;
  localparam logic [OP_W-1:0] OP_EVICT = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the accepted input word
    logic eval;      // match, pick a frame, start the readback
    logic commit;    // write back the table and load the output word
  } pft_cmd_t;

  // lowest set bit: {found, index}
  function automatic logic [FRAME_W:0] lowest_set(input logic [MAX_FRAMES-1:0] vec);
    logic [FRAME_W:0] r;
    r = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r = {1'b1, FRAME_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/page_frame_table_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_table_core
// Inverted page frame table with first-fit allocate, free, find and
// evict-and-allocate.
// ----------------------------------------------------------------------------
// Each word is evaluated and then written back: in the evaluation state
// the request is matched in parallel against all register-held entries
// and the lowest qualifying frame is priority encoded, which also starts
// the readback of the old owner and page from the entry RAM; in the
// write-back state the table is written back and the result is loaded
// into the output register. A new word is accepted in the write-back
// state while the output side keeps up, so one word can enter before
// the last has left; a stalled result holds the write-back until the
// output register frees. Reset clears all used marks, with no clearing
// pass. The frame count register takes effect on the next word.
module page_frame_table_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [pft_pkg::COUNT_W-1:0]  cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pft_pkg::OP_W-1:0]     op,
  input  logic [pft_pkg::PID_W-1:0]    process_id,
  input  logic [pft_pkg::PAGE_W-1:0]   page_number,
  input  logic [pft_pkg::FRAME_W-1:0]  frame_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         success,
  output logic [pft_pkg::FRAME_W-1:0]  result_frame,
  output logic                         displaced_valid,
  output logic [pft_pkg::PID_W-1:0]    displaced_process,
  output logic [pft_pkg::PAGE_W-1:0]   displaced_page
);

  pft_pkg::pft_cmd_t cmd;

  // sequencer
  pft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // table and datapath
  pft_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .cmd               (cmd),
    .op                (op),
    .process_id        (process_id),
    .page_number       (page_number),
    .frame_number      (frame_number),
    .success           (success),
    .result_frame      (result_frame),
    .displaced_valid   (displaced_valid),
    .displaced_process (displaced_process),
    .displaced_page    (displaced_page)
  );

endmodule

// ===== design/pft_ram.sv =====
// ----------------------------------------------------------------------------
// pft_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pft_ctrl.sv =====
// ----------------------------------------------------------------------------
// pft_ctrl
// Sequencer for the page frame table: accept, evaluate, write back, and
// the output word valid flag.
// ----------------------------------------------------------------------------
module pft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pft_pkg::pft_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_load;
  logic       accept;

  // output word can take a new result
  assign can_load = !out_valid || !out_stall;

  // take a new word when idle or while the current one retires
  assign in_stall = !((state == S_IDLE) || ((state == S_WB) && can_load));
  assign accept   = in_valid && !in_stall;

  // commands
  always_comb begin
    cmd.load_req = accept;
    cmd.eval     = (state == S_EVAL);
    cmd.commit   = (state == S_WB) && can_load;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_WB;
      end
      S_WB: begin
        if (can_load) begin
          state_next = accept ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // an accepted word is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EVAL))
    else $error("accepted word not evaluated");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.commit)
    else $error("pending result overwritten");

  // a commit always presents a result
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without output word");

  // no word taken during evaluation
  a_eval_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> in_stall)
    else $error("input taken during evaluation");

endmodule

// ===== design/pft_datapath.sv =====
// ----------------------------------------------------------------------------
// pft_datapath
// Frame table storage, parallel match and first-fit pick, readback RAM,
// frame count register and the output word.
// ----------------------------------------------------------------------------
module pft_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [pft_pkg::COUNT_W-1:0]  cfg_write_data,
  input  pft_pkg::pft_cmd_t            cmd,
  input  logic [pft_pkg::OP_W-1:0]     op,
  input  logic [pft_pkg::PID_W-1:0]    process_id,
  input  logic [pft_pkg::PAGE_W-1:0]   page_number,
  input  logic [pft_pkg::FRAME_W-1:0]  frame_number,
  output logic                         success,
  output logic [pft_pkg::FRAME_W-1:0]  result_frame,
  output logic                         displaced_valid,
  output logic [pft_pkg::PID_W-1:0]    displaced_process,
  output logic [pft_pkg::PAGE_W-1:0]   displaced_page
);

  // frame count
  logic [pft_pkg::COUNT_W-1:0] count;
  logic [pft_pkg::COUNT_W-1:0] active;

  // captured request
  logic [pft_pkg::OP_W-1:0]    req_op;
  logic [pft_pkg::PID_W-1:0]   req_pid;
  logic [pft_pkg::PAGE_W-1:0]  req_page;
  logic [pft_pkg::FRAME_W-1:0] req_fnum;

  // table: used marks and match copies of owner and page
  logic [pft_pkg::MAX_FRAMES-1:0] used;
  logic [pft_pkg::PID_W-1:0]      owner_cam [pft_pkg::MAX_FRAMES];
  logic [pft_pkg::PAGE_W-1:0]     page_cam  [pft_pkg::MAX_FRAMES];

  // match vectors
  logic [pft_pkg::MAX_FRAMES-1:0] in_range;
  logic [pft_pkg::MAX_FRAMES-1:0] free_vec;
  logic [pft_pkg::MAX_FRAMES-1:0] used_vec;
  logic [pft_pkg::MAX_FRAMES-1:0] match_vec;
  logic [pft_pkg::FRAME_W:0]      free_hit;
  logic [pft_pkg::FRAME_W:0]      used_hit;
  logic [pft_pkg::FRAME_W:0]      match_hit;

  // evaluation result
  logic                        ok_next;
  logic                        dv_next;
  logic [pft_pkg::FRAME_W-1:0] sel_next;
  logic                        ok;
  logic                        dv;
  logic [pft_pkg::FRAME_W-1:0] sel;

  // write back
  logic                        wr_entry;
  logic [pft_pkg::ENTRY_W-1:0] rd_entry;

  // frame count register, saturated to the table size where it is used
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= pft_pkg::COUNT_RESET;
    end else if (cfg_write_en) begin
      count <= cfg_write_data;
    end
  end

  assign active = (count > pft_pkg::COUNT_W'(pft_pkg::MAX_FRAMES)) ?
                  pft_pkg::COUNT_W'(pft_pkg::MAX_FRAMES) : count;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op   <= op;
      req_pid  <= process_id;
      req_page <= page_number;
      req_fnum <= frame_number;
    end
  end

  // per-frame range and match
  always_comb begin
    for (int i = 0; i < pft_pkg::MAX_FRAMES; i++) begin
      in_range[i]  = pft_pkg::COUNT_W'(i) < active;
      match_vec[i] = used[i] && in_range[i] &&
                     (owner_cam[i] == req_pid) && (page_cam[i] == req_page);
    end
    free_vec = ~used & in_range;
    used_vec = used & in_range;
  end

  assign free_hit  = pft_pkg::lowest_set(free_vec);
  assign used_hit  = pft_pkg::lowest_set(used_vec);
  assign match_hit = pft_pkg::lowest_set(match_vec);

  // frame pick per operation
  always_comb begin
    ok_next  = 1'b0;
    dv_next  = 1'b0;
    sel_next = '0;
    unique case (req_op)
      pft_pkg::OP_ALLOC: begin
        ok_next  = free_hit[pft_pkg::FRAME_W];
        sel_next = free_hit[pft_pkg::FRAME_W-1:0];
      end
      pft_pkg::OP_FREE: begin
        ok_next  = pft_pkg::COUNT_W'(req_fnum) < active;
        dv_next  = ok_next && used[req_fnum];
        sel_next = req_fnum;
      end
      pft_pkg::OP_FIND: begin
        ok_next  = match_hit[pft_pkg::FRAME_W];
        sel_next = match_hit[pft_pkg::FRAME_W-1:0];
      end
      pft_pkg::OP_EVICT: begin
        ok_next  = used_hit[pft_pkg::FRAME_W];
        dv_next  = ok_next;
        sel_next = used_hit[pft_pkg::FRAME_W-1:0];
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ok  <= ok_next;
      dv  <= dv_next;
      sel <= sel_next;
    end
  end

  // claim or re-own the picked frame
  assign wr_entry = cmd.commit && ok &&
                    ((req_op == pft_pkg::OP_ALLOC) || (req_op == pft_pkg::OP_EVICT));

  // used marks
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit && ok) begin
      if (req_op == pft_pkg::OP_ALLOC) begin
        used[sel] <= 1'b1;
      end else if (req_op == pft_pkg::OP_FREE) begin
        used[sel] <= 1'b0;
      end
    end
  end

  // match copies of owner and page
  always_ff @(posedge clk) begin
    if (wr_entry) begin
      owner_cam[sel] <= req_pid;
      page_cam[sel]  <= req_page;
    end
  end

  // readback copy for the displaced owner and page
  pft_ram #(
    .WIDTH (pft_pkg::ENTRY_W),
    .DEPTH (pft_pkg::MAX_FRAMES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_entry),
    .waddr (sel),
    .wdata ({req_pid, req_page}),
    .re    (cmd.eval),
    .raddr (sel_next),
    .rdata (rd_entry)
  );

  // output word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      success           <= ok;
      result_frame      <= ok ? sel : '0;
      displaced_valid   <= dv;
      displaced_process <= dv ? rd_entry[pft_pkg::ENTRY_W-1:pft_pkg::PAGE_W] : '0;
      displaced_page    <= dv ? rd_entry[pft_pkg::PAGE_W-1:0] : '0;
    end
  end

endmodule

// ===== bench/page_frame_table_core_test.sv =====
// ----------------------------------------------------------------------------
// page_frame_table_core_test
// Self-checking bench for the inverted page frame table. A shadow table
// predicts every result word; a bursty driver and a stalling receiver
// exercise the valid/stall handshakes across several frame count settings.
// ----------------------------------------------------------------------------
module page_frame_table_core_test;
  import pft_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 6;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] fnum;
  } frame_req_t;

  typedef struct packed {
    logic               success;
    logic [FRAME_W-1:0] frame;
    logic               disp_valid;
    logic [PID_W-1:0]   disp_pid;
    logic [PAGE_W-1:0]  disp_page;
  } frame_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  // block ports
  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_write_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op             = '0;
  logic [PID_W-1:0]   process_id     = '0;
  logic [PAGE_W-1:0]  page_number    = '0;
  logic [FRAME_W-1:0] frame_number   = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               success;
  logic [FRAME_W-1:0] result_frame;
  logic               displaced_valid;
  logic [PID_W-1:0]   displaced_process;
  logic [PAGE_W-1:0]  displaced_page;

  // shadow table and its frame count
  bit                 tbl_used  [MAX_FRAMES];
  logic [PID_W-1:0]   tbl_owner [MAX_FRAMES];
  logic [PAGE_W-1:0]  tbl_page  [MAX_FRAMES];
  logic [COUNT_W-1:0] frame_count_cfg = COUNT_RESET;

  frame_req_t    pending_reqs[$];
  frame_result_t expected_results[$];

  logic [PID_W-1:0]  pool_pid  [POOL_SIZE];
  logic [PAGE_W-1:0] pool_page [POOL_SIZE];

  int          error_count = 0;
  int          cycle_count = 0;
  bit          word_taken  = 1'b0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_span  = 0;
  int          stall_run   = 0;

  page_frame_table_core DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .op                (op),
    .process_id        (process_id),
    .page_number       (page_number),
    .frame_number      (frame_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .success           (success),
    .result_frame      (result_frame),
    .displaced_valid   (displaced_valid),
    .displaced_process (displaced_process),
    .displaced_page    (displaced_page)
  );

  always #10 clk = ~clk;

  // shadow table update and expected result word for one request
  function automatic frame_result_t apply_table_op(input frame_req_t req);
    frame_result_t res;
    int            lim;
    bit            done;
    res  = '0;
    done = 1'b0;
    lim  = (frame_count_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_cfg);
    case (req.op)
      OP_ALLOC: begin
        for (int i = 0; i < lim; i++) begin
          if (!done && !tbl_used[i]) begin
            tbl_used[i]  = 1'b1;
            tbl_owner[i] = req.pid;
            tbl_page[i]  = req.page;
            res.success  = 1'b1;
            res.frame    = FRAME_W'(i);
            done         = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (int'(req.fnum) < lim) begin
          res.success = 1'b1;
          res.frame   = req.fnum;
          if (tbl_used[req.fnum]) begin
            res.disp_valid = 1'b1;
            res.disp_pid   = tbl_owner[req.fnum];
            res.disp_page  = tbl_page[req.fnum];
          end
          tbl_used[req.fnum] = 1'b0;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < lim; i++) begin
          if (!done && tbl_used[i] && tbl_owner[i] == req.pid && tbl_page[i] == req.page) begin
            res.success = 1'b1;
            res.frame   = FRAME_W'(i);
            done        = 1'b1;
          end
        end
      end
      default: begin
        // evict and allocate: lowest used frame changes hands
        for (int i = 0; i < lim; i++) begin
          if (!done && tbl_used[i]) begin
            res.disp_valid = 1'b1;
            res.disp_pid   = tbl_owner[i];
            res.disp_page  = tbl_page[i];
            tbl_owner[i]   = req.pid;
            tbl_page[i]    = req.page;
            res.success    = 1'b1;
            res.frame      = FRAME_W'(i);
            done           = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic void push_req(input logic [OP_W-1:0] req_op, input logic [PID_W-1:0] pid,
                                   input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] fnum);
    frame_req_t r;
    r.op   = req_op;
    r.pid  = pid;
    r.page = page;
    r.fnum = fnum;
    pending_reqs.push_back(r);
  endfunction

  // a few owner/page pairs per phase so that finds can hit
  function automatic void refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_pid[i]  = PID_W'($urandom);
      pool_page[i] = PAGE_W'($urandom);
    end
    if ($urandom_range(0, 1) == 0) begin
      pool_pid[0]  = '0;
      pool_page[0] = '0;
      pool_pid[1]  = '1;
      pool_page[1] = '1;
    end
  endfunction

  function automatic frame_req_t random_req(input int eff);
    frame_req_t r;
    int         pick;
    int         sel;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.op = OP_ALLOC;
    else if (pick < 60) r.op = OP_FREE;
    else if (pick < 85) r.op = OP_FIND;
    else                r.op = OP_EVICT;
    if ($urandom_range(0, 3) != 0) begin
      sel    = $urandom_range(0, POOL_SIZE - 1);
      r.pid  = pool_pid[sel];
      r.page = pool_page[sel];
    end else begin
      r.pid  = PID_W'($urandom);
      r.page = PAGE_W'($urandom);
    end
    if (eff > 0 && $urandom_range(0, 6) != 0) r.fnum = FRAME_W'($urandom_range(0, eff - 1));
    else r.fnum = FRAME_W'($urandom);
    return r;
  endfunction

  // wait until every word is sent and answered, then let the pipe settle
  task automatic drain_table_ops();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en    <= 1'b0;
    frame_count_cfg  = value;
  endtask

  // request driver: bursts of words with random gaps
  always @(negedge clk) begin : req_driver
    frame_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        op           <= r.op;
        process_id   <= r.pid;
        page_number  <= r.page;
        frame_number <= r.fnum;
        in_valid     <= 1'b1;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, mode changes after a random span
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(10, 80);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          stall_run  = $urandom_range(1, 15);
          out_stall <= ~out_stall;
        end else begin
          stall_run--;
        end
      end
    endcase
  end

  // check result words, then predict accepted request words
  always @(posedge clk) begin : word_monitor
    frame_result_t got;
    frame_result_t want;
    word_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {success, result_frame, displaced_valid, displaced_process, displaced_page};
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result word with nothing expected, ok=%0d frame=%0d", $time,
                   got.success, got.frame);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            $display({"%0t: mismatch expected ok=%0d frame=%0d dv=%0d pid=%h page=%h",
                      " actual ok=%0d frame=%0d dv=%0d pid=%h page=%h"}, $time,
                     want.success, want.frame, want.disp_valid, want.disp_pid,
                     want.disp_page, got.success, got.frame, got.disp_valid,
                     got.disp_pid, got.disp_page);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_table_op({op, process_id, page_number, frame_number}));
        word_taken = 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int count_plan[10];
    int cnt;
    int eff;
    int n_items;
    count_plan = '{1, 2, 127, 3, 65, 0, 64, 16, 40, 8};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words on a four-frame table
    write_frame_count(COUNT_W'(4));
    push_req(OP_FIND,  8'h00, 16'h0000, 6'd0);   // find on empty table
    push_req(OP_EVICT, 8'h11, 16'h1111, 6'd0);   // evict with nothing used
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd0);   // free of an unused frame
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd63);  // free out of range
    push_req(OP_ALLOC, 8'hFF, 16'hFFFF, 6'd0);
    push_req(OP_ALLOC, 8'h00, 16'h0000, 6'd63);
    push_req(OP_ALLOC, 8'h5A, 16'h1234, 6'd0);
    push_req(OP_ALLOC, 8'hA5, 16'hEDCB, 6'd0);
    push_req(OP_ALLOC, 8'h3C, 16'h00FF, 6'd0);   // table full
    push_req(OP_FIND,  8'hFF, 16'hFFFF, 6'd0);
    push_req(OP_FIND,  8'h00, 16'h0000, 6'd0);
    push_req(OP_FIND,  8'hFF, 16'h0000, 6'd0);   // owner matches, page does not
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd4);   // just past the count
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd3);
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd3);   // now unused
    push_req(OP_EVICT, 8'h11, 16'h2222, 6'd0);
    push_req(OP_FIND,  8'h11, 16'h2222, 6'd0);
    push_req(OP_ALLOC, 8'h80, 16'h8000, 6'd0);
    push_req(OP_FIND,  8'hA5, 16'hEDCB, 6'd0);   // freed entry is gone
    push_req(OP_FREE,  8'h00, 16'h0000, 6'd0);
    push_req(OP_EVICT, 8'hC3, 16'hC3C3, 6'd0);
    drain_table_ops();

    // random phases over fixed and random frame counts
    for (int p = 0; p < 14; p++) begin
      cnt = (p < 10) ? count_plan[p] : $urandom_range(0, 127);
      eff = (cnt > MAX_FRAMES) ? MAX_FRAMES : cnt;
      n_items = (cnt == 0) ? 40 : ((p < 10) ? 150 : 120);
      write_frame_count(COUNT_W'(cnt));
      refresh_pool();
      repeat (n_items) pending_reqs.push_back(random_req(eff));
      drain_table_ops();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pft_pkg.sv
design/pft_ram.sv
design/pft_ctrl.sv
design/pft_datapath.sv
design/page_frame_table_core.sv
bench/page_frame_table_core_test.sv
